// ===== hdl/dap_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dap_pkg: shared types and constants of the distance amplitude panner
// Command and status types between controller and datapath, register
// indexes, default parameters and the Q.30 root table of the exp2 stage.
// ----------------------------------------------------------------------------
package dap_pkg;

    localparam int DEF_MAX_SPEAKERS = 16;
    localparam int DEF_CHANNEL_BITS = 6;
    localparam int RESULT_LIMIT     = 16;

    localparam int IN_BYTES_W  = 152;
    localparam int OUT_BYTES_W = 64;

    // configuration register indexes
    localparam logic REG_FOCUS  = 1'b0;
    localparam logic REG_ACTIVE = 1'b1;

    localparam logic [15:0] FOCUS_RESET  = 16'd4096;
    localparam logic [4:0]  ACTIVE_RESET = 5'd16;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_START,
        CMD_READ,
        CMD_SQ,
        CMD_SQRT,
        CMD_DIV,
        CMD_LNORM,
        CMD_LMUL,
        CMD_LUPD,
        CMD_PMUL,
        CMD_PSPLIT,
        CMD_EMUL,
        CMD_EUPD,
        CMD_GAIN,
        CMD_CMUL,
        CMD_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [4:0] step;
        logic       last;
    } dp_cmd_t;

    typedef struct packed {
        logic out_full;
    } dp_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_SQ,
        ST_SQRT,
        ST_DIV,
        ST_LNORM,
        ST_LMUL,
        ST_LUPD,
        ST_PMUL,
        ST_PSPLIT,
        ST_EMUL,
        ST_EUPD,
        ST_GAIN,
        ST_CMUL,
        ST_EMIT
    } dap_state_t;

    typedef logic [15:0][29:0] root_tab_t;

    // integer square root, elaboration only
    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = '0;
        b = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // root_k = 2^(-2^-k) in Q.30, entry k-1
    function automatic root_tab_t root_table();
        root_tab_t   t;
        logic [63:0] cur;
        cur  = isqrt64(64'd1 << 59);
        t[0] = cur[29:0];
        for (int k = 1; k < 16; k++)
        begin
            cur  = isqrt64(cur << 30);
            t[k] = cur[29:0];
        end
        return t;
    endfunction

    localparam root_tab_t EXP_ROOTS = root_table();

endpackage

// ===== hdl/dap_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dap_ctrl: sequencer of the panner
// Walks each render request through the speaker loop and steps the
// datapath through distance, reciprocal, log2, exp2 and product phases.
// ----------------------------------------------------------------------------
module dap_ctrl
    import dap_pkg::*;
#(
    parameter int MAX_SPEAKERS = DEF_MAX_SPEAKERS,
    localparam int SPK_AW = (MAX_SPEAKERS > 1) ? $clog2(MAX_SPEAKERS) : 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_op,
    output logic              in_ready,
    input  logic [4:0]        active,
    input  dp_stat_t          stat,
    output dp_cmd_t           cmd,
    output logic [SPK_AW-1:0] spk_addr
);

    localparam int CAP = (MAX_SPEAKERS < RESULT_LIMIT) ? MAX_SPEAKERS : RESULT_LIMIT;

    dap_state_t state_reg, state_next;
    logic [4:0] step_reg, step_next;
    logic [4:0] k_reg, k_next;
    logic [4:0] n_reg, n_next;
    logic [4:0] n_eff;
    logic       last;

    assign n_eff = (active > 5'(CAP)) ? 5'(CAP) : active;
    assign last  = (k_reg + 5'd1) == n_reg;

    // next state and counters
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg + 5'd1;
        k_next     = k_reg;
        n_next     = n_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                step_next = '0;
                if (in_valid && in_op && (n_eff != 5'd0))
                begin
                    state_next = ST_READ;
                    k_next     = '0;
                    n_next     = n_eff;
                end
            end
            ST_READ:
            begin
                state_next = ST_SQ;
                step_next  = '0;
            end
            ST_SQ:
            begin
                if (step_reg == 5'd3)
                begin
                    state_next = ST_SQRT;
                    step_next  = '0;
                end
            end
            ST_SQRT:
            begin
                if (step_reg == 5'd17)
                begin
                    state_next = ST_DIV;
                    step_next  = '0;
                end
            end
            ST_DIV:
            begin
                if (step_reg == 5'd23)
                begin
                    state_next = ST_LNORM;
                    step_next  = '0;
                end
            end
            ST_LNORM:
            begin
                state_next = ST_LMUL;
                step_next  = '0;
            end
            ST_LMUL:
            begin
                state_next = ST_LUPD;
                step_next  = step_reg;
            end
            ST_LUPD:
            begin
                state_next = (step_reg == 5'd15) ? ST_PMUL : ST_LMUL;
            end
            ST_PMUL:
            begin
                state_next = ST_PSPLIT;
            end
            ST_PSPLIT:
            begin
                state_next = ST_EMUL;
                step_next  = '0;
            end
            ST_EMUL:
            begin
                state_next = ST_EUPD;
                step_next  = step_reg;
            end
            ST_EUPD:
            begin
                state_next = (step_reg == 5'd15) ? ST_GAIN : ST_EMUL;
            end
            ST_GAIN:
            begin
                state_next = ST_CMUL;
            end
            ST_CMUL:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!stat.out_full)
                begin
                    if (last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_READ;
                        k_next     = k_reg + 5'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // commands to the datapath
    always_comb
    begin
        cmd.op   = CMD_NONE;
        cmd.step = step_reg;
        cmd.last = last;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op = in_op ? CMD_START : CMD_LOAD;
                end
            end
            ST_READ:   cmd.op = CMD_READ;
            ST_SQ:     cmd.op = CMD_SQ;
            ST_SQRT:   cmd.op = CMD_SQRT;
            ST_DIV:    cmd.op = CMD_DIV;
            ST_LNORM:  cmd.op = CMD_LNORM;
            ST_LMUL:   cmd.op = CMD_LMUL;
            ST_LUPD:   cmd.op = CMD_LUPD;
            ST_PMUL:   cmd.op = CMD_PMUL;
            ST_PSPLIT: cmd.op = CMD_PSPLIT;
            ST_EMUL:   cmd.op = CMD_EMUL;
            ST_EUPD:   cmd.op = CMD_EUPD;
            ST_GAIN:   cmd.op = CMD_GAIN;
            ST_CMUL:   cmd.op = CMD_CMUL;
            ST_EMIT:   cmd.op = CMD_EMIT;
            default:   cmd.op = CMD_NONE;
        endcase
    end

    assign spk_addr = SPK_AW'(k_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            k_reg     <= '0;
            n_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            k_reg     <= k_next;
            n_reg     <= n_next;
        end
    end

endmodule

// ===== hdl/dap_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dap_datapath: arithmetic and storage of the panner
// Speaker table, one shared 32x32 multiplier, bit-serial square root and
// divider, log2/exp2 registers and the result output register.
// ----------------------------------------------------------------------------
module dap_datapath
    import dap_pkg::*;
#(
    parameter int MAX_SPEAKERS = DEF_MAX_SPEAKERS,
    parameter int CHANNEL_BITS = DEF_CHANNEL_BITS,
    localparam int SPK_AW = (MAX_SPEAKERS > 1) ? $clog2(MAX_SPEAKERS) : 1
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  dp_cmd_t               cmd,
    input  logic [SPK_AW-1:0]     spk_addr,
    input  logic [IN_BYTES_W-1:0] in_data,
    input  logic [15:0]           focus,
    output dp_stat_t              stat,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_BYTES_W-1:0] m_tdata,
    output logic                  m_tlast
);

    // request fields
    logic [15:0] src_x, src_y, src_z, frame_in, sx, sy, sz;
    logic [23:0] audio;
    logic [3:0]  spk_index;
    logic [5:0]  spk_channel;

    assign src_x       = in_data[15:0];
    assign src_y       = in_data[31:16];
    assign src_z       = in_data[47:32];
    assign audio       = in_data[71:48];
    assign frame_in    = in_data[87:72];
    assign spk_index   = in_data[91:88];
    assign sx          = in_data[107:92];
    assign sy          = in_data[123:108];
    assign sz          = in_data[139:124];
    assign spk_channel = in_data[145:140];

    // speaker table
    logic [47:0]             pos_mem   [MAX_SPEAKERS];
    logic [CHANNEL_BITS-1:0] route_mem [MAX_SPEAKERS];
    logic [47:0]             pos_rd_reg;
    logic [CHANNEL_BITS-1:0] route_rd_reg;
    logic                    wr_en;

    assign wr_en = (cmd.op == CMD_LOAD) && (32'(spk_index) < MAX_SPEAKERS);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pos_mem[SPK_AW'(spk_index)]   <= {sz, sy, sx};
            route_mem[SPK_AW'(spk_index)] <= CHANNEL_BITS'(spk_channel);
        end
        if (cmd.op == CMD_READ)
        begin
            pos_rd_reg   <= pos_mem[spk_addr];
            route_rd_reg <= route_mem[spk_addr];
        end
    end

    // working registers
    logic signed [16:0] rx_reg, ry_reg, rz_reg;
    logic        [23:0] samp_abs_reg;
    logic               samp_neg_reg;
    logic        [15:0] frame_reg;
    logic        [63:0] prod_reg;
    logic        [34:0] acc_reg;
    logic        [35:0] rem_reg, root_reg;
    logic        [18:0] div_rem_reg;
    logic        [23:0] quo_reg;
    logic        [3:0]  e_reg, nexp_reg;
    logic        [15:0] frac_reg;
    logic        [31:0] x_reg;
    logic               big_reg;
    logic        [30:0] y_reg;
    logic        [15:0] gain_reg;
    logic               out_valid_reg;
    logic               out_last_reg;
    logic [OUT_BYTES_W-1:0] out_data_reg;

    // squared-distance component
    logic signed [17:0] diff;
    logic        [16:0] diff_abs;
    always_comb
    begin
        case (cmd.step[1:0])
            2'd0:    diff = 18'(rx_reg) - 18'($signed(pos_rd_reg[15:0]));
            2'd1:    diff = 18'(ry_reg) - 18'($signed(pos_rd_reg[31:16]));
            default: diff = 18'(rz_reg) - 18'($signed(pos_rd_reg[47:32]));
        endcase
        diff_abs = diff[17] ? 17'(-diff) : diff[16:0];
    end

    // square root step, two bits per cycle
    logic [35:0] rem_cur, root_cur, bitv, trial;
    logic        sq_ge;
    assign rem_cur  = (cmd.step == 5'd0) ? 36'(acc_reg) : rem_reg;
    assign root_cur = (cmd.step == 5'd0) ? '0 : root_reg;
    assign bitv     = 36'd1 << (6'd34 - {cmd.step, 1'b0});
    assign trial    = root_cur + bitv;
    assign sq_ge    = rem_cur >= trial;

    // restoring divide of 2^23 by 256 + d
    logic [17:0] divisor;
    logic [18:0] div_sh;
    logic        div_ge;
    assign divisor = 18'd256 + root_reg[17:0];
    assign div_sh  = {((cmd.step == 5'd0) ? 18'd0 : div_rem_reg[17:0]), (cmd.step == 5'd0)};
    assign div_ge  = div_sh >= 19'(divisor);

    // normalise g for log2
    logic [15:0] g_clip;
    logic [3:0]  lead;
    always_comb
    begin
        if (quo_reg == 24'd0)
        begin
            g_clip = 16'd1;
        end
        else if (quo_reg > 24'd32768)
        begin
            g_clip = 16'h8000;
        end
        else
        begin
            g_clip = quo_reg[15:0];
        end
        lead = '0;
        for (int i = 0; i < 16; i++)
        begin
            if (g_clip[i])
            begin
                lead = 4'(i);
            end
        end
    end

    logic [31:0] xs;
    logic [19:0] l_val;
    logic [23:0] p_val;
    logic [30:0] root_sel;
    logic [23:0] mag;
    assign xs       = prod_reg[61:30];
    assign l_val    = {4'd15, 16'd0} - {e_reg, frac_reg};
    assign p_val    = prod_reg[35:12];
    assign root_sel = frac_reg[4'd15 - cmd.step[3:0]] ? 31'(EXP_ROOTS[cmd.step[3:0]])
                                                      : (31'd1 << 30);
    assign mag      = prod_reg[38:15];

    // shared multiplier operands
    logic [31:0] mul_a, mul_b;
    always_comb
    begin
        case (cmd.op)
            CMD_SQ:
            begin
                mul_a = 32'(diff_abs);
                mul_b = 32'(diff_abs);
            end
            CMD_LMUL:
            begin
                mul_a = x_reg;
                mul_b = x_reg;
            end
            CMD_PMUL:
            begin
                mul_a = 32'(focus);
                mul_b = 32'(l_val);
            end
            CMD_EMUL:
            begin
                mul_a = 32'(y_reg);
                mul_b = 32'(root_sel);
            end
            default:
            begin
                mul_a = 32'(samp_abs_reg);
                mul_b = 32'(gain_reg);
            end
        endcase
    end

    logic out_load;
    assign stat.out_full = out_valid_reg && !m_tready;
    assign out_load      = (cmd.op == CMD_EMIT) && !stat.out_full;

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            CMD_START:
            begin
                rx_reg       <= 17'($signed(src_x));
                ry_reg       <= 17'sd0 - 17'($signed(src_z));
                rz_reg       <= 17'($signed(src_y));
                samp_neg_reg <= audio[23];
                samp_abs_reg <= audio[23] ? (24'd0 - audio) : audio;
                frame_reg    <= frame_in;
            end
            CMD_SQ:
            begin
                if (cmd.step != 5'd3)
                begin
                    prod_reg <= 64'(mul_a) * 64'(mul_b);
                end
                acc_reg <= (cmd.step == 5'd0) ? '0 : acc_reg + prod_reg[34:0];
            end
            CMD_SQRT:
            begin
                if (sq_ge)
                begin
                    rem_reg  <= rem_cur - trial;
                    root_reg <= (root_cur >> 1) + bitv;
                end
                else
                begin
                    rem_reg  <= rem_cur;
                    root_reg <= root_cur >> 1;
                end
            end
            CMD_DIV:
            begin
                div_rem_reg <= div_ge ? (div_sh - 19'(divisor)) : div_sh;
                quo_reg     <= {quo_reg[22:0], div_ge};
            end
            CMD_LNORM:
            begin
                e_reg <= lead;
                x_reg <= 32'(g_clip) << (5'd30 - 5'(lead));
            end
            CMD_LMUL, CMD_PMUL, CMD_EMUL, CMD_CMUL:
            begin
                prod_reg <= 64'(mul_a) * 64'(mul_b);
            end
            CMD_LUPD:
            begin
                x_reg    <= xs[31] ? {1'b0, xs[31:1]} : xs;
                frac_reg <= {frac_reg[14:0], xs[31]};
            end
            CMD_PSPLIT:
            begin
                big_reg  <= |p_val[23:20];
                nexp_reg <= p_val[19:16];
                frac_reg <= p_val[15:0];
                y_reg    <= 31'd1 << 30;
            end
            CMD_EUPD:
            begin
                y_reg <= prod_reg[60:30];
            end
            CMD_GAIN:
            begin
                gain_reg <= big_reg ? 16'd0 : 16'(y_reg >> (5'd15 + 5'(nexp_reg)));
            end
            default:
            begin
            end
        endcase
        if (out_load)
        begin
            out_data_reg <= {2'b00,
                             samp_neg_reg ? (24'd0 - mag) : mag,
                             gain_reg,
                             frame_reg,
                             6'(route_rd_reg)};
            out_last_reg <= cmd.last;
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== hdl/distance_amplitude_panner.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distance_amplitude_panner: distance-based amplitude panning
// Input stream s_*: tuser selects a speaker load (0) or a sample render (1).
// A load writes one speaker table entry and gives no result. A render gives
// one result per active speaker (active count capped at MAX_SPEAKERS and 16)
// on m_*, tlast on the final one, each with channel, frame, gain
// (1/(1+d/256))^focus and gain*sample. Per speaker the sequencer steps
// through read, squares, square root, divide, log2, power and product
// phases, then emits the result, waiting out any output stall; the shared
// 32x32 multiplier and serial units are used in turn. A new request is
// taken only once the last result of a render sits in the output register.
// The output register holds a result until m_tready; while it is full the
// sequencer waits before loading the next speaker's result.
// Reset clears control, focus to 1.0 and the active count to 16; the
// speaker table holds nothing valid until loaded.
// Configuration: cfg_we, cfg_index (0 focus, 1 active count), cfg_data.
// ----------------------------------------------------------------------------
module distance_amplitude_panner
    import dap_pkg::*;
#(
    parameter int MAX_SPEAKERS = DEF_MAX_SPEAKERS,
    parameter int CHANNEL_BITS = DEF_CHANNEL_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // src_x, src_y, src_z, audio_in, frame_number, spk_index,
    // spk_x, spk_y, spk_z, spk_channel, zero fill
    input  logic [IN_BYTES_W-1:0]  s_tdata,
    input  logic                   s_tuser,   // op
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // out_channel, out_frame, speaker_gain, contribution, zero fill
    output logic [OUT_BYTES_W-1:0] m_tdata,
    output logic                   m_tlast,   // last_speaker
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic [15:0]            cfg_data
);

    localparam int SPK_AW = (MAX_SPEAKERS > 1) ? $clog2(MAX_SPEAKERS) : 1;

    logic [15:0]       focus_reg;
    logic [4:0]        active_reg;
    dp_cmd_t           cmd;
    dp_stat_t          stat;
    logic [SPK_AW-1:0] spk_addr;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focus_reg  <= FOCUS_RESET;
            active_reg <= ACTIVE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FOCUS:  focus_reg  <= cfg_data;
                REG_ACTIVE: active_reg <= cfg_data[4:0];
                default:    focus_reg  <= focus_reg;
            endcase
        end
    end

    dap_ctrl #(
        .MAX_SPEAKERS (MAX_SPEAKERS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_op    (s_tuser),
        .in_ready (s_tready),
        .active   (active_reg),
        .stat     (stat),
        .cmd      (cmd),
        .spk_addr (spk_addr)
    );

    dap_datapath #(
        .MAX_SPEAKERS (MAX_SPEAKERS),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .spk_addr (spk_addr),
        .in_data  (s_tdata),
        .focus    (focus_reg),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== dv/tb_distance_amplitude_panner.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_distance_amplitude_panner: self-checking bench for the panner
// Loads every speaker entry, walks a directed table (typed results where the
// gain is obvious), then random phases over focus and active count with
// renders near loaded speakers plus random noise. Results are compared field
// by field against a bit-accurate fixed point gain predictor or typed values.
// ----------------------------------------------------------------------------
module tb_distance_amplitude_panner;
    import dap_pkg::*;

    typedef struct packed {
        logic [5:0]  channel;
        logic [15:0] frame;
        logic [15:0] gain;
        logic [23:0] contrib;
        logic        last;
    } pan_result_t;

    typedef struct {
        int          phase;
        logic        op;
        logic [15:0] sx, sy, sz;
        logic [23:0] audio;
        logic [15:0] frame;
        logic [3:0]  idx;
        logic [15:0] px, py, pz;
        logic [5:0]  ch;
        logic        typed;
        logic [15:0] t_gain;
        logic [23:0] t_contrib;
    } dir_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_BYTES_W-1:0]  s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_BYTES_W-1:0] m_tdata;
    logic                   m_tlast;
    logic                   cfg_we;
    logic                   cfg_index;
    logic [15:0]            cfg_data;

    // predictor state
    logic [15:0] spk_pos [16][3];
    logic [5:0]  spk_route [16];
    logic [15:0] cur_focus;
    logic [4:0]  cur_active;
    logic [63:0] root_q30 [16];

    pan_result_t gain_queue[$];
    dir_row_t    dir_tab[24];
    int          n_fail;
    int          n_loads;
    int          n_renders;
    int          n_results;
    bit          quiet;

    distance_amplitude_panner dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic logic [63:0] int_sqrt(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = '0;
        b = 64'd1 << 62;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // log2 in Q.16: leading one, then fraction by repeated squaring
    function automatic logic [31:0] log2_q16(input logic [31:0] g);
        int          e;
        logic [15:0] frac;
        logic [63:0] x;
        e    = 15;
        frac = '0;
        while (e > 0 && g[e] == 1'b0)
            e--;
        x = 64'(g) << (30 - e);
        for (int b = 15; b >= 0; b--)
        begin
            x = (x * x) >> 30;
            if (x >= (64'd1 << 31))
            begin
                frac[b] = 1'b1;
                x       = x >> 1;
            end
        end
        return (32'(e) << 16) | 32'(frac);
    endfunction

    // (1/(1+d/256))^focus via exp2(focus * log2(g))
    function automatic logic [15:0] falloff_gain(input logic [63:0] d);
        logic [63:0] g;
        logic [63:0] lg;
        logic [63:0] p;
        logic [63:0] y;
        logic [63:0] n;
        logic [15:0] f;
        g = (64'd1 << 23) / (64'd256 + d);
        if (g == 0)
            g = 1;
        if (g > 32768)
            g = 32768;
        lg = (64'd15 << 16) - 64'(log2_q16(g[31:0]));
        p  = (64'(cur_focus) * lg) >> 12;
        n  = p >> 16;
        f  = p[15:0];
        if (n >= 16)
            return 16'd0;
        y = 64'd1 << 30;
        for (int i = 15; i >= 0; i--)
            if (f[i])
                y = (y * root_q30[15 - i]) >> 30;
        y = y >> (15 + n);
        return y[15:0];
    endfunction

    // updates the table or queues one result per active speaker
    task automatic predict_request(input logic op, input logic [IN_BYTES_W-1:0] d,
                                   input bit typed, input logic [15:0] t_gain,
                                   input logic [23:0] t_contrib);
        logic signed [31:0] r [3];
        logic signed [31:0] dl;
        logic signed [31:0] smp;
        logic [63:0]        sq;
        logic [63:0]        mag;
        logic [15:0]        gn;
        int                 cnt;
        pan_result_t        res;
        if (op == 1'b0)
        begin
            n_loads++;
            spk_pos[d[91:88]][0] = d[107:92];
            spk_pos[d[91:88]][1] = d[123:108];
            spk_pos[d[91:88]][2] = d[139:124];
            spk_route[d[91:88]]  = d[145:140];
            return;
        end
        n_renders++;
        // remap source as (x, -z, y)
        r[0] = 32'(signed'(d[15:0]));
        r[1] = -32'(signed'(d[47:32]));
        r[2] = 32'(signed'(d[31:16]));
        smp  = 32'(signed'(d[71:48]));
        cnt  = (cur_active > 16) ? 16 : int'(cur_active);
        for (int k = 0; k < cnt; k++)
        begin
            sq = '0;
            for (int j = 0; j < 3; j++)
            begin
                dl = r[j] - 32'(signed'(spk_pos[k][j]));
                if (dl < 0)
                    dl = -dl;
                sq += 64'(dl) * 64'(dl);
            end
            gn  = falloff_gain(int_sqrt(sq));
            mag = (64'((smp < 0) ? -smp : smp) * 64'(gn)) >> 15;
            res.channel = spk_route[k];
            res.frame   = d[87:72];
            res.gain    = gn;
            res.contrib = (smp < 0) ? 24'(-mag) : 24'(mag);
            res.last    = (k + 1 == cnt);
            if (typed)
            begin
                res.gain    = t_gain;
                res.contrib = t_contrib;
            end
            gain_queue.push_back(res);
        end
    endtask

    task automatic send_request(input logic op, input logic [IN_BYTES_W-1:0] d,
                                input bit typed, input logic [15:0] t_gain,
                                input logic [23:0] t_contrib);
        while (!quiet && $urandom_range(99) < 14)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= d;
        do
            @(posedge clk);
        while (!s_tready);
        predict_request(op, d, typed, t_gain, t_contrib);
    endtask

    function automatic logic [IN_BYTES_W-1:0] pack_request(
        input logic [15:0] sx, input logic [15:0] sy, input logic [15:0] sz,
        input logic [23:0] audio, input logic [15:0] frame, input logic [3:0] idx,
        input logic [15:0] px, input logic [15:0] py, input logic [15:0] pz,
        input logic [5:0] ch);
        return {6'd0, ch, pz, py, px, idx, frame, audio, sz, sy, sx};
    endfunction

    // drain outstanding results, let the sequencer settle, then write both
    task automatic set_registers(input logic [15:0] fv, input logic [4:0] av);
        s_tvalid <= 1'b0;
        while (gain_queue.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_FOCUS;
        cfg_data  <= fv;
        @(posedge clk);
        cfg_index <= REG_ACTIVE;
        cfg_data  <= 16'(av);
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_focus  = fv;
        cur_active = av;
    endtask

    // result checker and output stall
    always @(posedge clk)
    begin
        pan_result_t got;
        pan_result_t want;
        if (rst_n)
        begin
            m_tready <= quiet || ($urandom_range(99) >= 14);
            if (m_tvalid && m_tready)
            begin
                got = {m_tdata[5:0], m_tdata[21:6], m_tdata[37:22], m_tdata[61:38],
                       m_tlast};
                n_results++;
                if (gain_queue.size() == 0)
                begin
                    $error("unexpected result channel=%0d frame=%0d", got.channel,
                           got.frame);
                    n_fail++;
                end
                else
                begin
                    want = gain_queue.pop_front();
                    if (got.channel !== want.channel)
                    begin
                        $error("out_channel exp %0d got %0d", want.channel, got.channel);
                        n_fail++;
                    end
                    if (got.frame !== want.frame)
                    begin
                        $error("out_frame exp %0d got %0d", want.frame, got.frame);
                        n_fail++;
                    end
                    if (got.gain !== want.gain)
                    begin
                        $error("speaker_gain exp %0d got %0d", want.gain, got.gain);
                        n_fail++;
                    end
                    if (got.contrib !== want.contrib)
                    begin
                        $error("contribution exp %0d got %0d", signed'(want.contrib),
                               signed'(got.contrib));
                        n_fail++;
                    end
                    if (got.last !== want.last)
                    begin
                        $error("last_speaker exp %0d got %0d", want.last, got.last);
                        n_fail++;
                    end
                end
            end
        end
    end

    // run limit
    initial
    begin
        #20000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        logic [IN_BYTES_W-1:0] d;
        logic [15:0]           fv;
        logic [4:0]            av;
        logic [15:0]           ox, oy, oz;
        int                    cur_phase;
        int                    k;
        s_tvalid  = 1'b0;
        s_tuser   = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_FOCUS;
        cfg_data  = '0;
        rst_n     = 1'b0;
        quiet     = 1'b0;
        n_fail    = 0;
        n_loads   = 0;
        n_renders = 0;
        n_results = 0;
        cur_focus  = FOCUS_RESET;
        cur_active = ACTIVE_RESET;
        // Q.30 roots of 2^(-2^-k)
        root_q30[0] = int_sqrt(64'd1 << 59);
        for (int i = 1; i < 16; i++)
            root_q30[i] = int_sqrt(root_q30[i - 1] << 30);

        // directed table: loads, some at field extremes, then renders
        for (int i = 0; i < 16; i++)
        begin
            dir_tab[i] = '{0, 1'b0, 16'h0, 16'h0, 16'h0, 24'h0, 16'h0, 4'(i),
                           16'($urandom), 16'($urandom), 16'($urandom), 6'($urandom),
                           1'b0, 16'h0, 24'h0};
        end
        dir_tab[0].px = 16'h0100;
        dir_tab[0].py = 16'h0200;
        dir_tab[0].pz = 16'hFD00;
        dir_tab[0].ch = 6'd63;
        dir_tab[1].px = 16'h8000;
        dir_tab[1].py = 16'h8000;
        dir_tab[1].pz = 16'h8000;
        dir_tab[1].ch = 6'd0;
        dir_tab[2].px = 16'h7FFF;
        dir_tab[2].py = 16'h7FFF;
        dir_tab[2].pz = 16'h7FFF;
        dir_tab[15].ch = 6'd42;
        dir_tab[16] = '{0, 1'b1, 16'h8000, 16'h8000, 16'h8000, 24'h800000, 16'h0000,
                        4'hF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 6'h3F, 1'b0, 16'h0, 24'h0};
        dir_tab[17] = '{0, 1'b1, 16'h7FFF, 16'h7FFF, 16'h7FFF, 24'h7FFFFF, 16'hFFFF,
                        4'h0, 16'h0, 16'h0, 16'h0, 6'h0, 1'b0, 16'h0, 24'h0};
        dir_tab[18] = '{0, 1'b1, 16'h0100, 16'hFD00, 16'hFE00, 24'h123456, 16'h1234,
                        4'h0, 16'h0, 16'h0, 16'h0, 6'h0, 1'b0, 16'h0, 24'h0};
        dir_tab[19] = '{0, 1'b1, 16'h0000, 16'h0000, 16'h0000, 24'hFFFFFF, 16'h0001,
                        4'h0, 16'h0, 16'h0, 16'h0, 6'h0, 1'b0, 16'h0, 24'h0};
        // focus zero: unity gain whatever the distance
        dir_tab[20] = '{1, 1'b1, 16'h8000, 16'h7FFF, 16'h8000, 24'h800000, 16'h00AA,
                        4'h0, 16'h0, 16'h0, 16'h0, 6'h0, 1'b1, 16'd32768, 24'h800000};
        dir_tab[21] = '{1, 1'b1, 16'h7FFF, 16'h8000, 16'h7FFF, 24'h7FFFFF, 16'h5555,
                        4'h0, 16'h0, 16'h0, 16'h0, 6'h0, 1'b1, 16'd32768, 24'h7FFFFF};
        // maximum focus: source on the speaker keeps unity, far source is silent
        dir_tab[22] = '{2, 1'b1, 16'h0100, 16'hFD00, 16'hFE00, 24'h400001, 16'h7777,
                        4'h0, 16'h0, 16'h0, 16'h0, 6'h0, 1'b1, 16'd32768, 24'h400001};
        dir_tab[23] = '{2, 1'b1, 16'h8000, 16'h7FFF, 16'h7FFF, 24'h7FFFFF, 16'h8888,
                        4'h0, 16'h0, 16'h0, 16'h0, 6'h0, 1'b1, 16'd0, 24'd0};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        cur_phase = 0;
        for (int i = 0; i < 24; i++)
        begin
            if (dir_tab[i].phase != cur_phase)
            begin
                cur_phase = dir_tab[i].phase;
                set_registers((cur_phase == 1) ? 16'd0 : 16'hFFFF, 5'd1);
            end
            d = pack_request(dir_tab[i].sx, dir_tab[i].sy, dir_tab[i].sz,
                             dir_tab[i].audio, dir_tab[i].frame, dir_tab[i].idx,
                             dir_tab[i].px, dir_tab[i].py, dir_tab[i].pz, dir_tab[i].ch);
            send_request(dir_tab[i].op, d, dir_tab[i].typed, dir_tab[i].t_gain,
                         dir_tab[i].t_contrib);
        end

        // random phases over focus and active count
        for (int ph = 0; ph < 8; ph++)
        begin
            case ($urandom_range(3))
                0: fv = 16'd0;
                1: fv = 16'hFFFF;
                2: fv = FOCUS_RESET;
                default: fv = 16'($urandom);
            endcase
            case ($urandom_range(2))
                0: av = 5'd1;
                1: av = 5'd16;
                default: av = 5'($urandom_range(16, 1));
            endcase
            set_registers(fv, av);
            quiet = (ph == 3 || ph == 4);
            for (int n = 0; n < 32; n++)
            begin
                if ($urandom_range(99) < 25)
                begin
                    d = pack_request(16'($urandom), 16'($urandom), 16'($urandom),
                                     24'($urandom), 16'($urandom), 4'($urandom),
                                     16'($urandom), 16'($urandom), 16'($urandom),
                                     6'($urandom));
                    send_request(1'b0, d, 1'b0, 16'h0, 24'h0);
                end
                else if ($urandom_range(99) < 65)
                begin
                    // source close to a loaded speaker, undoing the remap
                    k  = $urandom_range(15);
                    ox = 16'($urandom_range(1023)) - 16'd512;
                    oy = 16'($urandom_range(1023)) - 16'd512;
                    oz = 16'($urandom_range(1023)) - 16'd512;
                    d = pack_request(spk_pos[k][0] + ox, spk_pos[k][2] + oy,
                                     -spk_pos[k][1] + oz, 24'($urandom), 16'($urandom),
                                     4'($urandom), 16'($urandom), 16'($urandom),
                                     16'($urandom), 6'($urandom));
                    send_request(1'b1, d, 1'b0, 16'h0, 24'h0);
                end
                else
                begin
                    d = pack_request(16'($urandom), 16'($urandom), 16'($urandom),
                                     24'($urandom), 16'($urandom), 4'($urandom),
                                     16'($urandom), 16'($urandom), 16'($urandom),
                                     6'($urandom));
                    send_request(1'b1, d, 1'b0, 16'h0, 24'h0);
                end
            end
        end
        quiet = 1'b0;
        s_tvalid <= 1'b0;

        while (gain_queue.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (gain_queue.size() != 0)
        begin
            $error("%0d expected results never arrived", gain_queue.size());
            n_fail++;
        end

        $display("run covered %0d speaker loads and %0d renders, %0d results checked",
                 n_loads, n_renders, n_results);
        $display("settings swept: focus 0, 1.0, maximum and random; 1 to 16 speakers");
        if (n_fail == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/dap_pkg.sv
hdl/dap_ctrl.sv
hdl/dap_datapath.sv
hdl/distance_amplitude_panner.sv
dv/tb_distance_amplitude_panner.sv
